>>> design/lwcc_pkg.sv
// shared types and constants of the lru write-back cache tag controller
`default_nettype none

package lwcc_pkg;

  localparam int unsigned LWCC_ENTRIES   = 32;
  localparam int unsigned LWCC_ADDR_BITS = 16;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned WBA_W          = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_INSTALL = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic flush_step;
  } dp_cmd_t;

  typedef struct packed {
    logic flush_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/lwcc_ctrl.sv
// controller state machine sequencing accesses and the flush walk
`default_nettype none

module lwcc_ctrl
  import lwcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire dp_status_t        status_i,
  output dp_cmd_t                cmd_o,
  output logic                   busy_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (func_e'(func_i) == FUNC_FLUSH) ? ST_FLUSH : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FLUSH: begin
        cmd_o.flush_step = 1'b1;
        if (status_i.flush_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/lwcc_datapath.sv
// tag, valid, dirty and recency datapath with result registers
`default_nettype none

module lwcc_datapath
  import lwcc_pkg::*;
#(
  parameter int unsigned ENTRIES   = LWCC_ENTRIES,
  parameter int unsigned ADDR_BITS = LWCC_ADDR_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dp_cmd_t                    cmd_i,
  input  wire logic [FUNC_W-1:0]          func_i,
  input  wire logic [ADDR_BITS-1:0]       node_addr_i,
  output dp_status_t                      status_o,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [$clog2(ENTRIES)-1:0]      slot_o,
  output logic                            need_fill_o,
  output logic                            evict_valid_o,
  output logic                            write_back_o,
  output logic [ADDR_BITS-1:0]            write_back_addr_o,
  output logic                            last_o
);

  localparam int unsigned RANK_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);

  // entry state
  logic [ADDR_BITS-1:0] tag_q   [ENTRIES];
  logic [RANK_W-1:0]    rank_q  [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;
  logic [ENTRIES-1:0]   dirty_q;
  logic [OCC_W-1:0]     occ_q;

  // captured access
  func_e                func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ENTRIES-1:0]   match_q;
  logic [ENTRIES-1:0]   victim_q;
  logic [RANK_W-1:0]    walk_q;

  // result registers
  logic                 res_valid_q;
  logic                 hit_q;
  logic [RANK_W-1:0]    slot_q;
  logic                 fill_q;
  logic                 evict_q;
  logic                 wb_q;
  logic [ADDR_BITS-1:0] wba_q;
  logic                 last_q;

  logic                 hit;
  logic                 full;
  logic                 evict;
  logic [ENTRIES-1:0]   free_vec;
  logic [ENTRIES-1:0]   first_free;
  logic [ENTRIES-1:0]   sel;
  logic [ENTRIES-1:0]   fl_match;
  logic [ENTRIES-1:0]   fl_rest;
  logic                 fl_found;
  logic                 fl_rest_any;
  logic                 fl_emit;
  logic [ENTRIES-1:0]   pick;
  logic [RANK_W-1:0]    pick_slot;
  logic [ADDR_BITS-1:0] pick_tag;
  logic [RANK_W-1:0]    pick_rank;
  logic                 pick_dirty;
  logic [RANK_W-1:0]    old_rank;

  assign hit        = |match_q;
  assign full       = (occ_q == OCC_W'(ENTRIES));
  assign evict      = !hit && full;
  assign free_vec   = ~valid_q;
  assign first_free = free_vec & (~free_vec + ENTRIES'(1));
  assign sel        = hit ? match_q : (full ? victim_q : first_free);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      fl_match[i] = valid_q[i] && dirty_q[i] && (rank_q[i] == walk_q);
      fl_rest[i]  = valid_q[i] && dirty_q[i] && !fl_match[i];
    end
  end

  assign fl_found    = |fl_match;
  assign fl_rest_any = |fl_rest;
  assign fl_emit     = cmd_i.flush_step && (fl_found || !fl_rest_any);
  assign status_o.flush_last = !fl_rest_any;

  assign pick = cmd_i.flush_step ? fl_match : sel;

  always_comb begin
    pick_slot  = '0;
    pick_tag   = '0;
    pick_rank  = '0;
    pick_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (pick[i]) begin
        pick_slot  = pick_slot | RANK_W'(i);
        pick_tag   = pick_tag | tag_q[i];
        pick_rank  = pick_rank | rank_q[i];
        pick_dirty = pick_dirty | dirty_q[i];
      end
    end
  end

  // a new entry ages every other valid entry
  assign old_rank = (hit || full) ? pick_rank : RANK_W'(ENTRIES - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      addr_q <= node_addr_i;
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i]  <= valid_q[i] && (tag_q[i] == node_addr_i);
        victim_q[i] <= (rank_q[i] == RANK_W'(ENTRIES - 1));
      end
    end
    if (cmd_i.update && !hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          tag_q[i] <= addr_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      occ_q   <= '0;
      walk_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        walk_q <= '0;
      end else if (cmd_i.flush_step) begin
        walk_q <= walk_q + RANK_W'(1);
        dirty_q <= dirty_q & ~fl_match;
      end
      if (cmd_i.update) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (sel[i]) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
            if (hit) begin
              if (func_q == FUNC_WRITE) begin
                dirty_q[i] <= 1'b1;
              end else if (func_q == FUNC_INSTALL) begin
                dirty_q[i] <= 1'b0;
              end
            end else begin
              dirty_q[i] <= (func_q == FUNC_WRITE);
            end
          end else if (valid_q[i] && (rank_q[i] < old_rank)) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
        if (!hit && !full) begin
          occ_q <= occ_q + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.update || fl_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q   <= hit;
      slot_q  <= pick_slot;
      fill_q  <= !hit && (func_q == FUNC_READ);
      evict_q <= evict;
      wb_q    <= evict && pick_dirty;
      wba_q   <= (evict && pick_dirty) ? pick_tag : '0;
      last_q  <= 1'b1;
    end else if (fl_emit) begin
      hit_q   <= 1'b0;
      slot_q  <= pick_slot;
      fill_q  <= 1'b0;
      evict_q <= 1'b0;
      wb_q    <= fl_found;
      wba_q   <= fl_found ? pick_tag : '0;
      last_q  <= !fl_rest_any;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign hit_o             = hit_q;
  assign slot_o            = slot_q;
  assign need_fill_o       = fill_q;
  assign evict_valid_o     = evict_q;
  assign write_back_o      = wb_q;
  assign write_back_addr_o = wba_q;
  assign last_o            = last_q;

  // valid tags are unique
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(match_q))
    else $error("more than one entry matched the address");

  // a full cache has exactly one least recent entry
  a_victim_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && !hit && full) |-> $onehot(victim_q))
    else $error("no single eviction victim in a full cache");

  // valid dirty entries have distinct recency ranks
  a_flush_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_step |-> $onehot0(fl_match))
    else $error("two dirty entries share a recency rank");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

endmodule

`default_nettype wire

>>> design/lru_writeback_cache_controller_core.sv
// top level of the fully associative lru write-back cache tag controller
//
//  channel   signals                                   direction  handshake
//  access    func_i, node_addr_i                       in         start_i && !busy_o
//  result    hit_o, slot_o, need_fill_o, evict_valid_o out        result_valid_o strobe
//            write_back_o, write_back_addr_o, last_o
//
//  read, write and install go from idle to the access state and back to idle before
//  the next start is taken; their result word is strobed in the cycle after the entry update
//  flush walks recency ranks one per cycle from most recent, giving one word per
//  dirty entry, or one word if none is dirty; it ends at the least recent dirty entry
//  reset clears valid, dirty, rank and occupancy at once, no clearing pass
//  the receiver cannot stall: each result word is on the ports for one cycle
`default_nettype none

module lru_writeback_cache_controller_core
  import lwcc_pkg::*;
#(
  parameter int unsigned ENTRIES   = LWCC_ENTRIES,
  parameter int unsigned ADDR_BITS = LWCC_ADDR_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [FUNC_W-1:0]          func_i,
  input  wire logic [ADDR_BITS-1:0]       node_addr_i,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [$clog2(ENTRIES)-1:0]      slot_o,
  output logic                            need_fill_o,
  output logic                            evict_valid_o,
  output logic                            write_back_o,
  output logic [ADDR_BITS-1:0]            write_back_addr_o,
  output logic                            last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lwcc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lwcc_datapath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .func_i            (func_i),
    .node_addr_i       (node_addr_i),
    .status_o          (status),
    .result_valid_o    (result_valid_o),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .need_fill_o       (need_fill_o),
    .evict_valid_o     (evict_valid_o),
    .write_back_o      (write_back_o),
    .write_back_addr_o (write_back_addr_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the lru write-back cache tag controller
module tb;
  import lwcc_pkg::*;

  localparam int unsigned N           = LWCC_ENTRIES;
  localparam int unsigned AW          = LWCC_ADDR_BITS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned POOL_SIZE   = 40;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill;
    logic              evict;
    logic              wb;
    logic [WBA_W-1:0]  wb_addr;
    logic              last;
  } result_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [FUNC_W-1:0] func_i;
  logic [AW-1:0]     node_addr_i;
  logic              result_valid_o;
  logic              hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic              need_fill_o;
  logic              evict_valid_o;
  logic              write_back_o;
  logic [WBA_W-1:0]  write_back_addr_o;
  logic              last_o;

  // cache image kept by the testbench
  logic [AW-1:0] line_tag   [N];
  bit            line_valid [N];
  bit            line_dirty [N];
  int unsigned   line_rank  [N];
  int unsigned   line_count;

  result_word_t  pending_words [$];
  result_word_t  got_word;
  result_word_t  want_word;
  logic [AW-1:0] addr_pool [POOL_SIZE];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned words_seen;
  int unsigned func_count [4];
  int unsigned evictions;
  int unsigned write_backs;
  bit          steady;

  lru_writeback_cache_controller_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .node_addr_i       (node_addr_i),
    .result_valid_o    (result_valid_o),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .need_fill_o       (need_fill_o),
    .evict_valid_o     (evict_valid_o),
    .write_back_o      (write_back_o),
    .write_back_addr_o (write_back_addr_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               pending_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void promote_line(int way);
    int unsigned old;
    old = line_rank[way];
    for (int i = 0; i < N; i++)
      if (line_valid[i] && i != way && line_rank[i] < old)
        line_rank[i]++;
    line_rank[way] = 0;
  endfunction

  function automatic void predict_access(func_e f, logic [AW-1:0] addr);
    int way;
    int best;
    int dirty_total;
    int n;
    result_word_t w;
    way = -1;
    best = -1;
    dirty_total = 0;
    n = 0;
    w = '0;
    if (f == FUNC_FLUSH) begin
      for (int i = 0; i < N; i++)
        if (line_valid[i] && line_dirty[i])
          dirty_total++;
      if (dirty_total == 0) begin
        w.last = 1'b1;
        pending_words.push_back(w);
        return;
      end
      // most recent dirty entry first
      for (int r = 0; r < N; r++)
        for (int i = 0; i < N; i++)
          if (line_valid[i] && line_dirty[i] && line_rank[i] == r) begin
            n++;
            w = '0;
            w.slot = SLOT_W'(i);
            w.wb = 1'b1;
            w.wb_addr = WBA_W'(line_tag[i]);
            w.last = (n == dirty_total);
            pending_words.push_back(w);
            line_dirty[i] = 1'b0;
            write_backs++;
          end
      return;
    end
    for (int i = 0; i < N; i++)
      if (way < 0 && line_valid[i] && line_tag[i] == addr)
        way = i;
    if (way >= 0) begin
      if (f == FUNC_WRITE)
        line_dirty[way] = 1'b1;
      else if (f == FUNC_INSTALL)
        line_dirty[way] = 1'b0;
      promote_line(way);
      w.hit = 1'b1;
      w.slot = SLOT_W'(way);
      w.last = 1'b1;
      pending_words.push_back(w);
      return;
    end
    if (line_count >= N) begin
      for (int i = 0; i < N; i++)
        if (line_valid[i] && (best < 0 || line_rank[i] > line_rank[best]))
          best = i;
      if (best < 0)
        best = 0;
      way = best;
      w.evict = 1'b1;
      evictions++;
      if (line_valid[way] && line_dirty[way]) begin
        w.wb = 1'b1;
        w.wb_addr = WBA_W'(line_tag[way]);
        write_backs++;
      end
      promote_line(way);
    end else begin
      for (int i = 0; i < N; i++)
        if (way < 0 && !line_valid[i])
          way = i;
      if (way < 0)
        way = 0;
      for (int i = 0; i < N; i++)
        if (line_valid[i] && i != way && line_rank[i] < N - 1)
          line_rank[i]++;
      line_rank[way] = 0;
      line_count++;
    end
    line_valid[way] = 1'b1;
    line_tag[way] = addr;
    line_dirty[way] = (f == FUNC_WRITE);
    w.slot = SLOT_W'(way);
    w.fill = (f == FUNC_READ);
    w.last = 1'b1;
    pending_words.push_back(w);
  endfunction

  task automatic report_mismatch(string what, result_word_t want, result_word_t got);
    if (mismatches < 10) begin
      $display("%0t %s: expected hit=%0b slot=%0d fill=%0b evict=%0b wb=%0b wba=%h last=%0b",
               $realtime, what, want.hit, want.slot, want.fill, want.evict, want.wb,
               want.wb_addr, want.last);
      $display("    got hit=%0b slot=%0d fill=%0b evict=%0b wb=%0b wba=%h last=%0b",
               got.hit, got.slot, got.fill, got.evict, got.wb, got.wb_addr, got.last);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got_word = {hit_o, slot_o, need_fill_o, evict_valid_o, write_back_o,
                  write_back_addr_o, last_o};
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", '0, got_word);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word !== want_word)
          report_mismatch("word mismatch", want_word, got_word);
      end
    end
  end

  task automatic send_word(input func_e f, input logic [AW-1:0] addr);
    int unsigned gap;
    if (!steady && $urandom_range(99) < 25) begin
      gap = $urandom_range(3, 1);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    node_addr_i <= addr;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predict_access(f, addr);
    func_count[f]++;
    words_sent++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * N + 4) @(posedge clk_i);
  endtask

  function automatic func_e pick_func(int unsigned flush_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < flush_pct)
      return FUNC_FLUSH;
    else if (roll < flush_pct + 40)
      return FUNC_READ;
    else if (roll < flush_pct + 70)
      return FUNC_WRITE;
    else
      return FUNC_INSTALL;
  endfunction

  task automatic test_directed();
    send_word(FUNC_FLUSH, 16'hFFFF);
    send_word(FUNC_READ, 16'h0000);
    send_word(FUNC_READ, 16'hFFFF);
    send_word(FUNC_WRITE, 16'hFFFF);
    send_word(FUNC_READ, 16'hFFFF);
    send_word(FUNC_READ, 16'h0000);
    send_word(FUNC_INSTALL, 16'hFFFF);
    send_word(FUNC_WRITE, 16'h1234);
    send_word(FUNC_INSTALL, 16'h5555);
    send_word(FUNC_WRITE, 16'h0000);
    send_word(FUNC_FLUSH, 16'h0000);
    send_word(FUNC_FLUSH, AW'($urandom_range(16'hFFFF)));
    send_word(FUNC_INSTALL, 16'hAAAA);
    send_word(FUNC_WRITE, 16'h8001);
    send_word(FUNC_READ, 16'h7FFE);
    send_word(FUNC_WRITE, 16'h7FFE);
    send_word(FUNC_FLUSH, AW'($urandom_range(16'hFFFF)));
    wait_idle();
  endtask

  // fill every entry, then keep missing so the lru victim is taken
  task automatic test_fill_evict();
    logic [AW-1:0] addr;
    for (int i = 0; i < 40; i++) begin
      addr = AW'(32'hC000 | (i << 4) | $urandom_range(15));
      send_word(pick_func(0), addr);
    end
    for (int i = 0; i < 6; i++) begin
      addr = AW'(32'hC000 | ((39 - i) << 4) | $urandom_range(15));
      send_word(pick_func(0), addr);
    end
    send_word(FUNC_FLUSH, AW'($urandom_range(16'hFFFF)));
    send_word(FUNC_FLUSH, AW'($urandom_range(16'hFFFF)));
    wait_idle();
  endtask

  task automatic test_random_mix();
    logic [AW-1:0] addr;
    for (int i = 0; i < POOL_SIZE; i++)
      addr_pool[i] = AW'($urandom_range(16'hFFFF));
    for (int i = 0; i < 190; i++) begin
      steady = (i >= 60 && i < 120);
      if ($urandom_range(99) < 85)
        addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      else
        addr = AW'($urandom_range(16'hFFFF));
      send_word(pick_func(10), addr);
      if (i == 130)
        wait_idle();
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    func_i <= FUNC_READ;
    node_addr_i <= '0;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_seen = 0;
    evictions = 0;
    write_backs = 0;
    steady = 1'b0;
    line_count = 0;
    for (int i = 0; i < 4; i++)
      func_count[i] = 0;
    for (int i = 0; i < N; i++) begin
      line_tag[i] = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_rank[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_evict();
    test_random_mix();

    if (pending_words.size() != 0) begin
      $display("%0d expected words never arrived", pending_words.size());
      mismatches += pending_words.size();
    end
    $display("sent %0d accesses: %0d reads, %0d writes, %0d installs, %0d flushes",
             words_sent, func_count[FUNC_READ], func_count[FUNC_WRITE],
             func_count[FUNC_INSTALL], func_count[FUNC_FLUSH]);
    $display("checked %0d result words with %0d evictions and %0d write-backs, %0d errors",
             words_seen, evictions, write_backs, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lwcc_pkg.sv
design/lwcc_ctrl.sv
design/lwcc_datapath.sv
design/lru_writeback_cache_controller_core.sv
tb/tb.sv
